FILE: src/itf_pkg.sv
package itf_pkg;

  localparam int PRICE_W   = 32;
  localparam int ALPHA_W   = 17;
  localparam int CNT_W     = 3;
  localparam int WARMUP_DEF = 6;

  localparam int IN_DATA_W  = 88;  // price + alpha + seed_value, padded to bytes
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  // Datapath widths
  localparam int ACC_W  = 72;  // exact weighted sum, |sum| < 2^69
  localparam int RND_SH = 34;  // coefficients are scaled by 2^34
  localparam int Q_W    = ACC_W - RND_SH;
  localparam int A2_W   = 33;  // alpha squared, up to 2^32
  localparam int S_W    = 36;  // holding register for the two inner sums
  localparam int CHK_W  = 18;  // chunk width of the holding register
  localparam int MX_W   = 34;
  localparam int MY_W   = 19;
  localparam int PROD_W = MX_W + MY_W;

  // Microprogram
  localparam int UPC_W    = 4;
  localparam int N_STEPS  = 10;
  localparam logic [UPC_W-1:0] FIN_STEP = 4'd9;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_P0,
    SRC_P1,
    SRC_P2,
    SRC_Y1,
    SRC_Y2,
    SRC_PROD,
    SRC_HALF
  } src_t;

  localparam int N_SRC = 8;

  typedef enum logic [2:0] {
    SH_0,
    SH_1,
    SH_2,
    SH_18,
    SH_34,
    SH_35,
    SH_36
  } shamt_t;

  typedef enum logic {
    MX_A,
    MX_A2
  } mx_t;

  typedef enum logic [1:0] {
    MY_A,
    MY_SL,
    MY_SH
  } my_t;

  typedef enum logic {
    JC_NONE,
    JC_WARM
  } jc_t;

  typedef struct packed {
    src_t   t1_src;
    shamt_t t1_sh;
    logic   t1_neg;
    src_t   t2_src;
    shamt_t t2_sh;
    logic   t2_neg;
    logic   acc_keep;
    mx_t    mx;
    my_t    my;
    logic   a2_ld;
    logic   s_ld;
    jc_t    jc;
    upc_t   jtgt;
    logic   fin;
  } uword_t;

  // sum = A^2*S2 + 2^18*A*D + 2^34*(2*y1 - y2)
  //   S2 = -p0 + 2*p1 + 3*p2 - 4*y2
  //   D  =  p0 - p2 - 2*y1 + 2*y2
  localparam uword_t UCODE [N_STEPS] = '{
    // acc = -p0 + 2*p1, prod = A*A; warm-up items go straight to the output step
    '{SRC_P0,   SH_0,  1'b1, SRC_P1,   SH_1,  1'b0, 1'b0, MX_A,  MY_A,
      1'b0, 1'b0, JC_WARM, FIN_STEP, 1'b0},
    '{SRC_P2,   SH_1,  1'b0, SRC_P2,   SH_0,  1'b0, 1'b1, MX_A,  MY_A,
      1'b1, 1'b0, JC_NONE, 4'd0, 1'b0},
    '{SRC_Y2,   SH_2,  1'b1, SRC_NONE, SH_0,  1'b0, 1'b1, MX_A,  MY_A,
      1'b0, 1'b0, JC_NONE, 4'd0, 1'b0},
    // hold S2, start D
    '{SRC_P0,   SH_0,  1'b0, SRC_P2,   SH_0,  1'b1, 1'b0, MX_A,  MY_A,
      1'b0, 1'b1, JC_NONE, 4'd0, 1'b0},
    '{SRC_Y1,   SH_1,  1'b1, SRC_Y2,   SH_1,  1'b0, 1'b1, MX_A2, MY_SL,
      1'b0, 1'b0, JC_NONE, 4'd0, 1'b0},
    // hold D, final sum starts with A2*S2 low chunk
    '{SRC_PROD, SH_0,  1'b0, SRC_Y1,   SH_35, 1'b0, 1'b0, MX_A2, MY_SH,
      1'b0, 1'b1, JC_NONE, 4'd0, 1'b0},
    '{SRC_PROD, SH_18, 1'b0, SRC_Y2,   SH_34, 1'b1, 1'b1, MX_A,  MY_SL,
      1'b0, 1'b0, JC_NONE, 4'd0, 1'b0},
    '{SRC_PROD, SH_18, 1'b0, SRC_HALF, SH_0,  1'b0, 1'b1, MX_A,  MY_SH,
      1'b0, 1'b0, JC_NONE, 4'd0, 1'b0},
    '{SRC_PROD, SH_36, 1'b0, SRC_NONE, SH_0,  1'b0, 1'b1, MX_A,  MY_A,
      1'b0, 1'b0, JC_NONE, 4'd0, 1'b0},
    // round, saturate, deliver
    '{SRC_NONE, SH_0,  1'b0, SRC_NONE, SH_0,  1'b0, 1'b1, MX_A,  MY_A,
      1'b0, 1'b0, JC_NONE, 4'd0, 1'b1}
  };

  function automatic logic signed [ACC_W-1:0] shl(input logic signed [ACC_W-1:0] v,
                                                   input shamt_t s);
    case (s)
      SH_0:    shl = v;
      SH_1:    shl = v << 1;
      SH_2:    shl = v << 2;
      SH_18:   shl = v << 18;
      SH_34:   shl = v << 34;
      SH_35:   shl = v << 35;
      SH_36:   shl = v << 36;
      default: shl = v;
    endcase
  endfunction

endpackage

FILE: src/instantaneous_trendline_filter_core.sv
// One item at a time: a new item is accepted only once the previous one has left the
// output step, and warm-up items jump from the first step to the output step. The
// ten-step microprogram runs every product through one shared 34x19 multiplier
// and one accumulator. A result waiting at the output holds the last step only.
// Reset (rst_n low, synchronous): clears price/trend history and the warm-up count.
module instantaneous_trendline_filter_core
  import itf_pkg::*;
#(
  parameter int WARMUP = WARMUP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // price[31:0], alpha[48:32], seed_value[80:49]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // trend[31:0]
  output logic [OUT_USER_W-1:0] out_tuser   // in_warmup[0], saturated[1]
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  upc_t   upc_r;
  uword_t uw;

  logic signed [PRICE_W-1:0] p0_r, seed_r;
  logic [ALPHA_W-1:0]        a_r;
  logic                      warm_r;
  logic signed [PRICE_W-1:0] last_price_r, older_price_r, last_trend_r, older_trend_r;
  logic [CNT_W-1:0]          count_r;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [A2_W-1:0]          a2_r;
  logic signed [S_W-1:0]    s_r;

  logic signed [ACC_W-1:0]  src_v [N_SRC];
  logic signed [ACC_W-1:0]  t1, t2;
  logic signed [MX_W-1:0]   mx_v;
  logic signed [MY_W-1:0]   my_v;

  logic signed [Q_W-1:0]     q;
  logic                      ovf;
  logic signed [PRICE_W-1:0] y_fin;
  logic                      sat_fin;

  logic                      out_valid_r;
  logic [PRICE_W-1:0]        out_trend_r;
  logic                      out_warm_r, out_sat_r;

  logic in_acc, fin_go;

  assign uw        = UCODE[upc_r];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fin_go    = (state_r == ST_RUN) && uw.fin && (!out_valid_r || out_tready);

  // Operand sources, sign-extended to the accumulator width
  always_comb begin
    src_v[SRC_NONE] = '0;
    src_v[SRC_P0]   = {{(ACC_W-PRICE_W){p0_r[PRICE_W-1]}}, p0_r};
    src_v[SRC_P1]   = {{(ACC_W-PRICE_W){last_price_r[PRICE_W-1]}}, last_price_r};
    src_v[SRC_P2]   = {{(ACC_W-PRICE_W){older_price_r[PRICE_W-1]}}, older_price_r};
    src_v[SRC_Y1]   = {{(ACC_W-PRICE_W){last_trend_r[PRICE_W-1]}}, last_trend_r};
    src_v[SRC_Y2]   = {{(ACC_W-PRICE_W){older_trend_r[PRICE_W-1]}}, older_trend_r};
    src_v[SRC_PROD] = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    src_v[SRC_HALF] = {{(ACC_W-RND_SH){1'b0}}, 1'b1, {(RND_SH-1){1'b0}}};
  end

  always_comb begin
    t1 = shl(src_v[uw.t1_src], uw.t1_sh);
    t2 = shl(src_v[uw.t2_src], uw.t2_sh);
    if (uw.t1_neg) begin
      t1 = -t1;
    end
    if (uw.t2_neg) begin
      t2 = -t2;
    end
    acc_nxt = (uw.acc_keep ? acc_r : '0) + t1 + t2;
  end

  always_comb begin
    unique case (uw.mx)
      MX_A:  mx_v = {{(MX_W-ALPHA_W){1'b0}}, a_r};
      MX_A2: mx_v = {{(MX_W-A2_W){1'b0}}, a2_r};
    endcase
    case (uw.my)
      MY_A:    my_v = {{(MY_W-ALPHA_W){1'b0}}, a_r};
      MY_SL:   my_v = {{(MY_W-CHK_W){1'b0}}, s_r[CHK_W-1:0]};
      MY_SH:   my_v = {s_r[S_W-1], s_r[S_W-1:CHK_W]};
      default: my_v = '0;
    endcase
    prod_nxt = mx_v * my_v;
  end

  // Round (half already added), then clip to the 32-bit range; warm-up items take the seed
  always_comb begin
    q   = acc_r[ACC_W-1:RND_SH];
    ovf = (q[Q_W-1:PRICE_W-1] != {(Q_W-PRICE_W+1){q[PRICE_W-1]}});
    if (warm_r) begin
      y_fin   = seed_r;
      sat_fin = 1'b0;
    end else if (ovf) begin
      y_fin   = q[Q_W-1] ? {1'b1, {(PRICE_W-1){1'b0}}} : {1'b0, {(PRICE_W-1){1'b1}}};
      sat_fin = 1'b1;
    end else begin
      y_fin   = q[PRICE_W-1:0];
      sat_fin = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      upc_r         <= '0;
      out_valid_r   <= 1'b0;
      out_trend_r   <= '0;
      out_warm_r    <= 1'b0;
      out_sat_r     <= 1'b0;
      count_r       <= '0;
      last_price_r  <= '0;
      older_price_r <= '0;
      last_trend_r  <= '0;
      older_trend_r <= '0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
        out_trend_r <= y_fin;
        out_warm_r  <= warm_r;
        out_sat_r   <= sat_fin;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_RUN;
            upc_r   <= '0;
          end
        end
        ST_RUN: begin
          if (uw.fin) begin
            if (fin_go) begin
              state_r       <= ST_IDLE;
              older_price_r <= last_price_r;
              last_price_r  <= p0_r;
              older_trend_r <= last_trend_r;
              last_trend_r  <= y_fin;
              if (warm_r) begin
                count_r <= count_r + 1'b1;
              end
            end
          end else if (uw.jc == JC_WARM && warm_r) begin
            upc_r <= uw.jtgt;
          end else begin
            upc_r <= upc_r + 1'b1;
          end
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p0_r   <= in_tdata[PRICE_W-1:0];
      a_r    <= (in_tdata[PRICE_W+ALPHA_W-1:PRICE_W] > ALPHA_ONE) ? ALPHA_ONE
                : in_tdata[PRICE_W+ALPHA_W-1:PRICE_W];
      seed_r <= in_tdata[2*PRICE_W+ALPHA_W-1:PRICE_W+ALPHA_W];
      warm_r <= (count_r < CNT_W'(WARMUP));
    end
    if (state_r == ST_RUN && !uw.fin) begin
      acc_r  <= acc_nxt;
      prod_r <= prod_nxt;
      if (uw.a2_ld) begin
        a2_r <= prod_r[A2_W-1:0];
      end
      if (uw.s_ld) begin
        s_r <= acc_r[S_W-1:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_trend_r;
  assign out_tuser  = {out_sat_r, out_warm_r};

`ifndef SYNTHESIS
  a_rise_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_RUN && upc_r == FIN_STEP))
    else $error("result appeared outside the output step");

  a_warm_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("warm-up item flagged as saturated");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WARMUP))
    else $error("warm-up count ran past its limit");

  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> upc_r <= FIN_STEP)
    else $error("step counter left the program");
`endif

endmodule
